// ----- rtl/core/assert_macros.svh -----
// Assertion macros used by the checker module of this project.
// No dependencies; included by files that hold concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion clocked on clk_i, off while rst_ni is low.
`define ASSERT_CLKD(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication checked every cycle out of reset.
`define ASSERT_IMPL(label, ante, cons, msg) \
  `ASSERT_CLKD(label, (ante) |-> (cons), msg)

// Implication with the consequent checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
  `ASSERT_CLKD(label, (ante) |=> (cons), msg)

`endif

// ----- rtl/core/cbe_pkg.sv -----
// Package for the counted bitmap engine: sizes, mode codes, payload types.
// No dependencies; used by every module of the block but cbe_ram.
`default_nettype none

package cbe_pkg;

  // Sizes
  localparam int MaxBits   = 1024;
  localparam int ChunkBits = 8;
  localparam int NumChunks = MaxBits / ChunkBits;
  localparam int ChunkIdxW = 7;
  localparam int BitIdxW   = 10;
  localparam int CountW    = 11;
  localparam int ModeW     = 4;
  localparam int PopW      = 4;

  localparam logic [CountW-1:0] LimitMax = CountW'(MaxBits);

  // Mode codes
  localparam logic [ModeW-1:0] MODE_SET    = 4'd0;
  localparam logic [ModeW-1:0] MODE_CLEAR  = 4'd1;
  localparam logic [ModeW-1:0] MODE_WRITE  = 4'd2;
  localparam logic [ModeW-1:0] MODE_TEST   = 4'd3;
  localparam logic [ModeW-1:0] MODE_COPY   = 4'd4;
  localparam logic [ModeW-1:0] MODE_AND    = 4'd5;
  localparam logic [ModeW-1:0] MODE_OR     = 4'd6;
  localparam logic [ModeW-1:0] MODE_DIFF   = 4'd7;
  localparam logic [ModeW-1:0] MODE_NEGATE = 4'd8;

  // Request and result payloads
  typedef struct packed {
    logic [ModeW-1:0]     mode;
    logic [BitIdxW-1:0]   bit_index;
    logic                 bit_value;
    logic [ChunkIdxW-1:0] chunk_index;
    logic [ChunkBits-1:0] source_byte;
  } cbe_in_t;

  typedef struct packed {
    logic              bit_read;
    logic              changed;
    logic [CountW-1:0] count_set;
    logic              range_error;
  } cbe_out_t;

  // Update stage to top level: write-back and result
  typedef struct packed {
    logic                 wr_en;
    logic [ChunkBits-1:0] wr_data;
    cbe_out_t             result;
  } cbe_upd_t;

  typedef enum logic {
    ST_IDLE,
    ST_UPDATE
  } cbe_state_e;

  // Ones per nibble
  localparam logic [2:0] NibbleOnes [16] = '{
    3'd0, 3'd1, 3'd1, 3'd2, 3'd1, 3'd2, 3'd2, 3'd3,
    3'd1, 3'd2, 3'd2, 3'd3, 3'd2, 3'd3, 3'd3, 3'd4
  };

  function automatic logic [PopW-1:0] pop_chunk(logic [ChunkBits-1:0] v);
    logic [PopW-1:0] lo;
    logic [PopW-1:0] hi;
    lo = {1'b0, NibbleOnes[v[3:0]]};
    hi = {1'b0, NibbleOnes[v[7:4]]};
    return lo + hi;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/cbe_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
`default_nettype none

module cbe_ram #(
  parameter int Width = 8,
  parameter int Depth = 128
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read, holds between reads
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/cbe_update.sv -----
// Modify step: new chunk, tested bit, change flag, range check and set-bit count.
// Depends on cbe_pkg.
`default_nettype none

module cbe_update (
  input  wire logic                           [cbe_pkg::CountW-1:0]    limit_i,
  input  wire logic                           [cbe_pkg::CountW-1:0]    count_i,
  input  wire cbe_pkg::cbe_in_t                                        req_i,
  input  wire logic                           [cbe_pkg::ChunkBits-1:0] old_i,
  output cbe_pkg::cbe_upd_t                                            upd_o
);

  logic [cbe_pkg::ChunkBits-1:0] bit_mask;
  logic [cbe_pkg::ChunkBits-1:0] keep_mask;
  logic [cbe_pkg::ChunkBits-1:0] new_chunk;
  logic [cbe_pkg::CountW-1:0]    first_bit;
  logic [cbe_pkg::CountW-1:0]    span;
  logic [cbe_pkg::CountW-1:0]    pop_old;
  logic                          bit_err;
  logic                          chunk_err;

  // Range checks and masks
  assign bit_mask  = cbe_pkg::ChunkBits'(1) << req_i.bit_index[2:0];
  assign first_bit = {1'b0, req_i.chunk_index, 3'b000};
  assign bit_err   = {1'b0, req_i.bit_index} >= limit_i;
  assign chunk_err = first_bit >= limit_i;
  assign span      = limit_i - first_bit;
  assign keep_mask = (span >= cbe_pkg::CountW'(cbe_pkg::ChunkBits)) ? '1
                   : (cbe_pkg::ChunkBits'(1) << span[2:0]) - cbe_pkg::ChunkBits'(1);
  assign pop_old   = cbe_pkg::CountW'(cbe_pkg::pop_chunk(old_i));

  always_comb begin
    new_chunk          = old_i;
    upd_o              = '0;
    upd_o.result.count_set = count_i;
    if (req_i.mode inside {[cbe_pkg::MODE_SET:cbe_pkg::MODE_TEST]}) begin
      // Single-bit modes
      if (bit_err) begin
        upd_o.result.range_error = 1'b1;
      end else begin
        case (req_i.mode)
          cbe_pkg::MODE_SET:   new_chunk = old_i | bit_mask;
          cbe_pkg::MODE_CLEAR: new_chunk = old_i & ~bit_mask;
          cbe_pkg::MODE_WRITE: new_chunk = req_i.bit_value ? (old_i | bit_mask)
                                                           : (old_i & ~bit_mask);
          default:             upd_o.result.bit_read = |(old_i & bit_mask);
        endcase
        if (new_chunk != old_i) begin
          upd_o.result.changed   = 1'b1;
          upd_o.wr_en            = 1'b1;
          upd_o.result.count_set = |(new_chunk & bit_mask)
                                 ? count_i + cbe_pkg::CountW'(1)
                                 : count_i - cbe_pkg::CountW'(1);
        end
      end
    end else if (req_i.mode inside {[cbe_pkg::MODE_COPY:cbe_pkg::MODE_NEGATE]}) begin
      // Whole-chunk modes, trimmed to bits in use
      if (chunk_err) begin
        upd_o.result.range_error = 1'b1;
      end else begin
        case (req_i.mode)
          cbe_pkg::MODE_COPY: new_chunk = req_i.source_byte;
          cbe_pkg::MODE_AND:  new_chunk = old_i & req_i.source_byte;
          cbe_pkg::MODE_OR:   new_chunk = old_i | req_i.source_byte;
          cbe_pkg::MODE_DIFF: new_chunk = old_i & ~req_i.source_byte;
          default:            new_chunk = ~old_i;
        endcase
        new_chunk = new_chunk & keep_mask;
        if (new_chunk != old_i) begin
          upd_o.result.changed   = 1'b1;
          upd_o.wr_en            = 1'b1;
          upd_o.result.count_set = count_i - pop_old
                                 + cbe_pkg::CountW'(cbe_pkg::pop_chunk(new_chunk));
        end
      end
    end
    upd_o.wr_data = new_chunk;
  end

endmodule

`default_nettype wire

// ----- rtl/core/counted_bitmap_engine.sv -----
// Counted bitmap engine top level: request handshake, chunk RAM, count register.
// Depends on cbe_pkg, cbe_ram and cbe_update.
//
//  channel  | signals                             | direction
//  ---------+-------------------------------------+----------
//  request  | in_valid_i, in_ready_o, in_data_i   | in
//  result   | out_valid_o, out_ready_i, out_data_o| out
//  config   | cfg_valid_i, cfg_ready_o, cfg_data_i| in
//
// Each request reads its chunk from the RAM when accepted; in ST_UPDATE the chunk is
// modified, written back and the result registered. One request is in flight at a time.
// Reset clears the per-chunk valid bits, so the bitmap reads as zero at once.
// A held result register stalls the modify step; the config port is always ready.
`default_nettype none

module counted_bitmap_engine (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 in_valid_i,
  output logic                                      in_ready_o,
  input  wire cbe_pkg::cbe_in_t                     in_data_i,
  output logic                                      out_valid_o,
  input  wire logic                                 out_ready_i,
  output cbe_pkg::cbe_out_t                         out_data_o,
  input  wire logic                                 cfg_valid_i,
  output logic                                      cfg_ready_o,
  input  wire logic           [cbe_pkg::CountW-1:0] cfg_data_i
);

  cbe_pkg::cbe_state_e              state_q, state_d;
  cbe_pkg::cbe_in_t                 req_q;
  cbe_pkg::cbe_out_t                out_q;
  cbe_pkg::cbe_upd_t                upd;
  logic                             out_valid_q, out_valid_d;
  logic [cbe_pkg::CountW-1:0]       limit_q;
  logic [cbe_pkg::CountW-1:0]       count_q;
  logic [cbe_pkg::NumChunks-1:0]    valid_q;
  logic                             entry_valid_q;
  logic [cbe_pkg::ChunkIdxW-1:0]    rd_addr;
  logic [cbe_pkg::ChunkIdxW-1:0]    wr_addr;
  logic [cbe_pkg::ChunkBits-1:0]    rd_data;
  logic [cbe_pkg::ChunkBits-1:0]    old_chunk;
  logic                             accept;
  logic                             load;

  assign cfg_ready_o = 1'b1;
  assign accept      = in_valid_i && in_ready_o;

  // Chunk address of a request
  assign rd_addr = (in_data_i.mode inside {[cbe_pkg::MODE_SET:cbe_pkg::MODE_TEST]})
                 ? in_data_i.bit_index[cbe_pkg::BitIdxW-1:3] : in_data_i.chunk_index;
  assign wr_addr = (req_q.mode inside {[cbe_pkg::MODE_SET:cbe_pkg::MODE_TEST]})
                 ? req_q.bit_index[cbe_pkg::BitIdxW-1:3] : req_q.chunk_index;

  cbe_ram #(
    .Width (cbe_pkg::ChunkBits),
    .Depth (cbe_pkg::NumChunks)
  ) u_chunk_ram (
    .clk_i   (clk_i),
    .we_i    (load && upd.wr_en),
    .waddr_i (wr_addr),
    .wdata_i (upd.wr_data),
    .re_i    (accept),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  // Never-written chunks read as zero
  assign old_chunk = entry_valid_q ? rd_data : '0;

  cbe_update u_update (
    .limit_i (limit_q),
    .count_i (count_q),
    .req_i   (req_q),
    .old_i   (old_chunk),
    .upd_o   (upd)
  );

  // Next state and handshake
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    in_ready_o  = 1'b0;
    load        = 1'b0;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      cbe_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          state_d = cbe_pkg::ST_UPDATE;
        end
      end
      cbe_pkg::ST_UPDATE: begin
        if (!out_valid_q || out_ready_i) begin
          load        = 1'b1;
          out_valid_d = 1'b1;
          state_d     = cbe_pkg::ST_IDLE;
        end
      end
      default: state_d = cbe_pkg::ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cbe_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      count_q     <= '0;
      limit_q     <= cbe_pkg::LimitMax;
      valid_q     <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (load) begin
        count_q <= upd.result.count_set;
      end
      if (load && upd.wr_en) begin
        valid_q[wr_addr] <= 1'b1;
      end
      // Limit saturates at the bitmap size
      if (cfg_valid_i) begin
        limit_q <= (cfg_data_i > cbe_pkg::LimitMax) ? cbe_pkg::LimitMax : cfg_data_i;
      end
    end
  end

  // Request and result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q         <= in_data_i;
      entry_valid_q <= valid_q[rd_addr];
    end
    if (load) begin
      out_q <= upd.result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// ----- rtl/core/cbe_checker.sv -----
// Port-level checker for the counted bitmap engine, bound to the top level.
// Depends on cbe_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module cbe_checker (
  input wire logic                                 clk_i,
  input wire logic                                 rst_ni,
  input wire logic                                 in_valid_i,
  input wire logic                                 in_ready_o,
  input wire logic                                 out_valid_o,
  input wire logic                                 out_ready_i,
  input wire cbe_pkg::cbe_out_t                    out_data_o
);

  // Result holds while stalled
  `ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o), "result dropped or changed while stalled")

  // Count never exceeds the bitmap size
  `ASSERT_IMPL(a_count_max, out_valid_o, out_data_o.count_set <= cbe_pkg::LimitMax, "count_set beyond bitmap size")

  // Rejected requests change nothing
  `ASSERT_IMPL(a_err_nochg, out_valid_o && out_data_o.range_error, !out_data_o.changed && !out_data_o.bit_read, "range error with change or read")

  // A tested bit never comes with a change
  `ASSERT_IMPL(a_read_nochg, out_valid_o && out_data_o.bit_read, !out_data_o.changed, "bit test changed the bitmap")

  // One request in flight: no accept in the following cycle
  `ASSERT_NEXT(a_one_inflight, in_valid_i && in_ready_o, !in_ready_o, "request accepted back to back")

endmodule

bind counted_bitmap_engine cbe_checker u_cbe_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire
